// ----- hdl/b2d_pkg.sv -----
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared widths and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CNT_W   = $clog2(VALUE_W);
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  // ASCII '0' is 6'h30, so a digit character is the digit with the top two bits set
  localparam logic [1:0] CHAR_ZERO_HI = 2'b11;

  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  // handoff from the converter to the emitter
  typedef struct packed {
    logic valid;
    logic ovf;
  } handoff_t;

endpackage

`default_nettype wire

// ----- hdl/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 64-bit binary to a fixed run of ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each input beat carries a 64-bit value; the block answers with NUM_DIGITS
// output beats, one ASCII digit each, most significant first, zero padded.
// last_digit_o marks the final beat; overflow_o is set on every beat of a run
// whose value does not fit, and the run then holds the low NUM_DIGITS digits.
// Conversion is bit-serial double-dabble, one input bit per cycle; in_stall_o
// goes high once an item is accepted and stays high while its bits shift in
// and until the output register takes the result. The NUM_DIGITS output
// beats drain from their own shift register while the next value converts,
// so a new value can be taken before the digits of the last one have all
// been sent, as long as the sink keeps up.
`default_nettype none

module binary_to_decimal_ascii
  import b2d_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 19
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [VALUE_W-1:0]   value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CHAR_W-1:0]         digit_char_o,
  output logic                      last_digit_o,
  output logic                      overflow_o
);

  handoff_t                          hand;
  logic                              take;
  logic [NUM_DIGITS*DIGIT_W-1:0]     bcd;

  b2d_conv #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .take_i     (take),
    .hand_o     (hand),
    .bcd_o      (bcd)
  );

  b2d_emit #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hand_i       (hand),
    .bcd_i        (bcd),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .overflow_o   (overflow_o)
  );

endmodule

`default_nettype wire

// ----- hdl/b2d_digit.sv -----
// ----------------------------------------------------------------------------
// b2d_digit
// One BCD digit of the double-dabble chain: add-3 adjust, then shift in a bit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_digit
  import b2d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               clear_i,
  input  wire logic               shift_i,
  input  wire logic               carry_i,
  output logic                    carry_o,
  output logic [DIGIT_W-1:0]      digit_o
);

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_q >= ADJ_LIMIT) ? digit_q + ADJ_ADD : digit_q;
    carry_o = adj[DIGIT_W-1];
    digit_d = digit_q;
    if (clear_i) begin
      digit_d = '0;
    end else if (shift_i) begin
      digit_d = {adj[DIGIT_W-2:0], carry_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// ----- hdl/b2d_conv.sv -----
// ----------------------------------------------------------------------------
// b2d_conv
// Bit-serial double-dabble: one input bit per cycle into a row of BCD cells.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_conv
  import b2d_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 19
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [VALUE_W-1:0]            value_i,
  input  wire logic                          take_i,
  output handoff_t                           hand_o,
  output logic [NUM_DIGITS*DIGIT_W-1:0]      bcd_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] sreg_q, sreg_d;
  logic               accept;
  logic [NUM_DIGITS:0] carry;

  assign in_stall_o = busy_q | done_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // lowest cell takes the next input bit, MSB first
  assign carry[0] = sreg_q[VALUE_W-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    b2d_digit u_digit (
      .clk_i   (clk_i),
      .clear_i (accept),
      .shift_i (busy_q),
      .carry_i (carry[i]),
      .carry_o (carry[i+1]),
      .digit_o (bcd_o[i*DIGIT_W +: DIGIT_W])
    );
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    sreg_d = sreg_q;
    if (accept) begin
      busy_d = 1'b1;
      ovf_d  = 1'b0;
      cnt_d  = '0;
      sreg_d = value_i;
    end else if (busy_q) begin
      sreg_d = {sreg_q[VALUE_W-2:0], 1'b0};
      // carry out of the top digit means the value is at least 10^NUM_DIGITS
      ovf_d  = ovf_q | carry[NUM_DIGITS];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (done_q && take_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    sreg_q <= sreg_d;
  end

  assign hand_o.valid = done_q;
  assign hand_o.ovf   = ovf_q;

endmodule

`default_nettype wire

// ----- hdl/b2d_emit.sv -----
// ----------------------------------------------------------------------------
// b2d_emit
// Output shift register: sends the BCD digits as ASCII, one beat per digit.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_emit
  import b2d_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 19
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire handoff_t                      hand_i,
  input  wire logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  output logic                               take_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [CHAR_W-1:0]                  digit_char_o,
  output logic                               last_digit_o,
  output logic                               overflow_o
);

  localparam int unsigned IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

  logic             valid_q, valid_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [BCD_W-1:0] digits_q, digits_d;
  logic             ovf_q, ovf_d;
  logic             beat, last;

  assign last   = (cnt_q == '0);
  assign beat   = valid_q & ~out_stall_i;
  assign take_o = hand_i.valid & (~valid_q | (beat & last));

  always_comb begin
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    ovf_d    = ovf_q;
    if (take_o) begin
      valid_d  = 1'b1;
      cnt_d    = IDX_W'(NUM_DIGITS - 1);
      digits_d = bcd_i;
      ovf_d    = hand_i.ovf;
    end else if (beat) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        cnt_d    = cnt_q - 1'b1;
        digits_d = digits_q << DIGIT_W;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    ovf_q    <= ovf_d;
  end

  assign out_valid_o  = valid_q;
  assign digit_char_o = {CHAR_ZERO_HI, digits_q[BCD_W-1 -: DIGIT_W]};
  assign last_digit_o = last;
  assign overflow_o   = ovf_q;

endmodule

`default_nettype wire

// ----- hdl/b2d_checker.sv -----
// ----------------------------------------------------------------------------
// b2d_checker
// Port-level checks for binary_to_decimal_ascii, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_checker
  import b2d_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [CHAR_W-1:0] digit_char_o,
  input wire logic              last_digit_o,
  input wire logic              overflow_o
);

  // every beat is an ASCII decimal digit
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o[5:4] == 2'b11) && (digit_char_o[3:0] <= 4'd9))
    else $error("digit character out of range");

  // a run does not break up, and its overflow flag holds over the run
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_digit_o
      |=> out_valid_o && (overflow_o == $past(overflow_o)))
    else $error("run broken or overflow changed mid-run");

  // the converter is busy right after taking a value
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken while converting");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
      |=> out_valid_o && $stable(digit_char_o) && $stable(last_digit_o))
    else $error("stalled output beat changed");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o),
  .overflow_o   (overflow_o)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// A directed table covers zero, single digits, the 19/20 digit boundary, the
// all-ones value and alternating bit patterns. Random values follow: full
// width, small, near the overflow boundary, near the top of the range,
// powers of ten or one below, and full-width values shifted right. Each
// accepted value is expanded into its expected digit beats. Every output
// beat is checked field by field against the oldest pending beat. Both
// sides idle at random, except in a stretch with no idling at all.
module tb_top
  import b2d_pkg::*;
();

  localparam int unsigned NUM_DIGITS   = 19;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TEXT_W       = NUM_DIGITS * 8;

  localparam logic [VALUE_W-1:0] TEN       = 64'd10;
  localparam logic [VALUE_W-1:0] TEN_POW19 = 64'd10000000000000000000;
  localparam logic [CHAR_W-1:0]  ASCII_0   = 6'd48;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              ovf;
  } digit_beat_t;

  // typed = 1: expected run is spelled out in text/ovf; otherwise predicted
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               typed;
    logic [TEXT_W-1:0]  text;
    logic               ovf;
  } vector_row_t;

  localparam int unsigned NUM_ROWS = 16;
  localparam vector_row_t VECTORS [NUM_ROWS] = '{
    '{64'd0,                    1'b1, "0000000000000000000", 1'b0},
    '{64'd1,                    1'b1, "0000000000000000001", 1'b0},
    '{64'd9,                    1'b1, "0000000000000000009", 1'b0},
    '{64'd10,                   1'b1, "0000000000000000010", 1'b0},
    '{64'd999999999999999999,   1'b1, "0999999999999999999", 1'b0},
    '{64'd1000000000000000000,  1'b1, "1000000000000000000", 1'b0},
    '{64'd1234567890123456789,  1'b1, "1234567890123456789", 1'b0},
    '{64'd9999999999999999999,  1'b1, "9999999999999999999", 1'b0},
    '{64'd10000000000000000000, 1'b1, "0000000000000000000", 1'b1},
    '{64'd10000000000000000001, 1'b1, "0000000000000000001", 1'b1},
    '{64'h8000_0000_0000_0000,  1'b1, "9223372036854775808", 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF,  1'b1, "8446744073709551615", 1'b1},
    '{64'h5555_5555_5555_5555,  1'b0, '0,                    1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA,  1'b0, '0,                    1'b0},
    '{64'd12345678901234567890, 1'b0, '0,                    1'b0},
    '{64'h0000_0000_FFFF_FFFF,  1'b0, '0,                    1'b0}
  };

  logic               clk_i;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;
  logic               overflow;

  digit_beat_t pending_digits[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned beat_count  = 0;
  logic        steady      = 1'b0;

  binary_to_decimal_ascii #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .digit_char_o(digit_char),
    .last_digit_o(last_digit),
    .overflow_o  (overflow)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Decimal expansion of one value: low NUM_DIGITS digits, MSD first.
  task automatic queue_decimal_run(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [3:0]         digs [NUM_DIGITS];
    logic               ovf;
    digit_beat_t        b;
    rest = v;
    for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
      digs[p] = 4'(rest % TEN);
      rest    = rest / TEN;
    end
    ovf = (rest != '0);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      b.ch   = ASCII_0 + CHAR_W'(digs[k]);
      b.last = (k == NUM_DIGITS - 1);
      b.ovf  = ovf;
      pending_digits.push_back(b);
    end
  endtask

  task automatic queue_spelled_run(input vector_row_t row);
    digit_beat_t b;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      b.ch   = row.text[(NUM_DIGITS - 1 - k) * 8 +: CHAR_W];
      b.last = (k == NUM_DIGITS - 1);
      b.ovf  = row.ovf;
      pending_digits.push_back(b);
    end
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      4, 5: v = VALUE_W'($urandom_range(0, 999));
      6:    v = TEN_POW19 - 64'd50 + VALUE_W'($urandom_range(0, 100));
      7:    v = '1 - VALUE_W'($urandom_range(0, 1000));
      8: begin
        v = 64'd1;
        repeat ($urandom_range(0, 19)) v = v * TEN;
        v = v - VALUE_W'($urandom_range(0, 1));
      end
      9:    v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic maybe_idle();
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Returns once the beat has been taken.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Output side: random stall, check every accepted beat.
  always @(posedge clk_i) begin
    digit_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beat_count++;
      if (pending_digits.size() == 0) begin
        note_failure($sformatf("beat %0d: char %0d last %0b ovf %0b, nothing pending",
                               beat_count, digit_char, last_digit, overflow));
      end else begin
        want = pending_digits.pop_front();
        if (digit_char !== want.ch || last_digit !== want.last ||
            overflow !== want.ovf)
          note_failure($sformatf(
            "beat %0d: exp char %0d last %0b ovf %0b, got char %0d last %0b ovf %0b",
            beat_count, want.ch, want.last, want.ovf,
            digit_char, last_digit, overflow));
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      maybe_idle();
      send_value(VECTORS[i].value);
      if (VECTORS[i].typed) queue_spelled_run(VECTORS[i]);
      else                  queue_decimal_run(VECTORS[i].value);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // no idling on either side for a long stretch
      steady <= (i >= 120 && i < 200);
      maybe_idle();
      v = random_value();
      send_value(v);
      queue_decimal_run(v);
    end
    in_valid <= 1'b0;
    steady   <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
